### src/piah_pkg.sv
package piah_pkg;

	localparam int NUM_BINS      = 128;
	localparam int INTERVAL_BINS = 60;
	localparam int COUNT_WIDTH   = 32;

	localparam int PHASE_W   = 12;
	localparam int AMP_W     = 8;
	localparam int OP_W      = 2;
	localparam int BIN_OUT_W = 7;
	localparam int COUNT_OUT_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam int BIN_W  = $clog2(NUM_BINS);
	localparam int IDX_W  = 9;
	localparam int DIFF_W = PHASE_W + 1;

	localparam int WRAP_50HZ     = 1800;
	localparam int WRAP_60HZ     = 2160;
	localparam int PHASE_PER_BIN = 18;
	localparam int RECIP_SHIFT   = 16;
	localparam int RECIP         = ((1 << RECIP_SHIFT) + PHASE_PER_BIN - 1) / PHASE_PER_BIN;
	localparam int INTERVAL_SPAN = INTERVAL_BINS * PHASE_PER_BIN;

	localparam logic [OP_W-1:0] OP_PULSE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ60  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_MIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AMP_MAX = 2'd3;

	localparam logic signed [AMP_W-1:0] AMP_MIN_RESET = -8'sd60;
	localparam logic signed [AMP_W-1:0] AMP_MAX_RESET = 8'sd60;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic update;
	} piah_cmd_t;

endpackage

### src/piah_ram.sv
module piah_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/piah_ctrl.sv
module piah_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output piah_pkg::piah_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   accept;

	assign accept = start && !busy_q;
	assign busy = busy_q;

	assign cmd.capture = accept;
	assign cmd.lookup  = (state_q == ST_LOOKUP);
	assign cmd.update  = (state_q == ST_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q) inside
				ST_IDLE, ST_UPDATE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
						busy_q  <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_UPDATE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q && state_q == ST_UPDATE)
		else $error("busy held longer than the lookup cycle");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(start))
		else $error("busy rose without a start");

endmodule

### src/piah_dp.sv
module piah_dp (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  piah_pkg::piah_cmd_t                        cmd,
	input  logic [piah_pkg::OP_W-1:0]                  op,
	input  logic [piah_pkg::PHASE_W-1:0]               phase_pos,
	input  logic signed [piah_pkg::AMP_W-1:0]          amplitude,
	input  logic                                       first_of_list,
	input  logic [piah_pkg::BIN_OUT_W-1:0]             read_bin,
	input  logic                                       cfg_we,
	input  logic [piah_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [piah_pkg::CFG_DATA_W-1:0]            cfg_data,
	output logic                                       strobe,
	output logic [piah_pkg::BIN_OUT_W-1:0]             bin,
	output logic [piah_pkg::COUNT_OUT_W-1:0]           count,
	output logic                                       counted
);

	localparam int CW = piah_pkg::COUNT_WIDTH;
	localparam int PW = piah_pkg::PHASE_W;
	localparam int DW = piah_pkg::DIFF_W;
	localparam int IW = piah_pkg::IDX_W;
	localparam int BW = piah_pkg::BIN_W;
	localparam int MW = 2 * 32;
	localparam int PRW = 2 * PW;

	logic                               mode_q;
	logic                               freq60_q;
	logic signed [piah_pkg::AMP_W-1:0]  amp_min_q;
	logic signed [piah_pkg::AMP_W-1:0]  amp_max_q;
	logic [PW-1:0]                      last_phase_q;

	logic [piah_pkg::OP_W-1:0]          op_q;
	logic                               first_q;
	logic [piah_pkg::BIN_OUT_W-1:0]     rbin_q;
	logic signed [DW-1:0]               diff_q;
	logic [IW-1:0]                      amp_idx_q;
	logic                               amp_ok_q;

	logic signed [DW-1:0]               wrapped;
	logic [PRW-1:0]                     product;
	logic [IW-1:0]                      iv_idx;
	logic                               iv_ok;
	logic [IW-1:0]                      hit_idx;
	logic                               hit_ok;
	logic                               rd_ok;
	logic [BW-1:0]                      raddr;

	logic [piah_pkg::OP_W-1:0]          op_s2;
	logic                               hit_s2;
	logic                               rd_ok_s2;
	logic [IW-1:0]                      idx_s2;
	logic [piah_pkg::BIN_OUT_W-1:0]     rbin_s2;
	logic                               valid_s2;

	logic [piah_pkg::NUM_BINS-1:0]      valid_q;
	logic [CW-1:0]                      rdata;
	logic [CW-1:0]                      cur;
	logic [CW-1:0]                      next_cnt;
	logic [piah_pkg::COUNT_OUT_W-1:0]   cur_out;
	logic [piah_pkg::COUNT_OUT_W-1:0]   next_out;
	logic                               we;

	logic                               strobe_q;
	logic [piah_pkg::BIN_OUT_W-1:0]     bin_q;
	logic [piah_pkg::COUNT_OUT_W-1:0]   count_q;
	logic                               counted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			freq60_q  <= 1'b0;
			amp_min_q <= piah_pkg::AMP_MIN_RESET;
			amp_max_q <= piah_pkg::AMP_MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				piah_pkg::CFG_MODE:    mode_q    <= cfg_data[0];
				piah_pkg::CFG_FREQ60:  freq60_q  <= cfg_data[0];
				piah_pkg::CFG_AMP_MIN: amp_min_q <= signed'(cfg_data);
				piah_pkg::CFG_AMP_MAX: amp_max_q <= signed'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// The interval is taken against the phase before this pulse overwrites it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_phase_q <= '0;
		end else if (cmd.capture && op == piah_pkg::OP_PULSE) begin
			last_phase_q <= phase_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= op;
			first_q   <= first_of_list;
			rbin_q    <= read_bin;
			diff_q    <= signed'({1'b0, phase_pos}) - signed'({1'b0, last_phase_q});
			amp_idx_q <= IW'(signed'(IW'(amplitude)) - signed'(IW'(amp_min_q)));
			amp_ok_q  <= (amplitude >= amp_min_q) && (amplitude <= amp_max_q);
		end
	end

	always_comb begin
		if (diff_q < 0) begin
			wrapped = diff_q + (freq60_q ? DW'(piah_pkg::WRAP_60HZ) : DW'(piah_pkg::WRAP_50HZ));
		end else begin
			wrapped = diff_q;
		end
		product = PRW'(wrapped[PW-1:0]) * PRW'(piah_pkg::RECIP);
		if (wrapped < 0) begin
			iv_idx = '0;
			iv_ok  = (wrapped > -DW'(piah_pkg::PHASE_PER_BIN));
		end else begin
			iv_idx = IW'(product >> piah_pkg::RECIP_SHIFT);
			iv_ok  = (wrapped < DW'(piah_pkg::INTERVAL_SPAN));
		end
		if (mode_q) begin
			hit_idx = iv_idx;
			hit_ok  = iv_ok && !first_q;
		end else begin
			hit_idx = amp_idx_q;
			hit_ok  = amp_ok_q;
		end
		hit_ok = hit_ok && (hit_idx < IW'(piah_pkg::NUM_BINS));
		rd_ok  = (IW'(rbin_q) < IW'(piah_pkg::NUM_BINS));
		if (op_q == piah_pkg::OP_READ) begin
			raddr = BW'(rbin_q);
		end else begin
			raddr = BW'(hit_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			op_s2    <= op_q;
			hit_s2   <= hit_ok;
			rd_ok_s2 <= rd_ok;
			idx_s2   <= hit_idx;
			rbin_s2  <= rbin_q;
			valid_s2 <= valid_q[raddr];
		end
	end

	piah_ram #(
		.WIDTH(CW),
		.DEPTH(piah_pkg::NUM_BINS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(BW'(idx_s2)),
		.wdata(next_cnt),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		cur      = valid_s2 ? rdata : '0;
		next_cnt = (cur == '1) ? cur : cur + CW'(1);
		cur_out  = (MW'(cur) > MW'(32'hFFFF_FFFF)) ? '1 : piah_pkg::COUNT_OUT_W'(cur);
		next_out = (MW'(next_cnt) > MW'(32'hFFFF_FFFF)) ? '1 : piah_pkg::COUNT_OUT_W'(next_cnt);
		we       = cmd.update && (op_s2 == piah_pkg::OP_PULSE) && hit_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.update && op_s2 == piah_pkg::OP_CLEAR) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[BW'(idx_s2)] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.update;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			bin_q     <= '0;
			count_q   <= '0;
			counted_q <= 1'b0;
			case (op_s2)
				piah_pkg::OP_PULSE: begin
					if (hit_s2) begin
						bin_q     <= piah_pkg::BIN_OUT_W'(idx_s2);
						count_q   <= next_out;
						counted_q <= 1'b1;
					end
				end
				piah_pkg::OP_READ: begin
					bin_q <= rbin_s2;
					if (rd_ok_s2) begin
						count_q <= cur_out;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign strobe  = strobe_q;
	assign bin     = bin_q;
	assign count   = count_q;
	assign counted = counted_q;

	a_strobe_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(cmd.update))
		else $error("result strobe without an update cycle");

	a_counted_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && counted_q |-> count_q != '0)
		else $error("counted pulse reports a zero count");

	a_clear_drops_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && op_s2 == piah_pkg::OP_CLEAR |=> valid_q == '0)
		else $error("clear left a bin marked as written");

endmodule

### src/pulse_interval_amplitude_histogram_core.sv
// Channel  Direction  Ports                                             Handshake
// command  in         op, phase_pos, amplitude, first_of_list, read_bin start, busy
// result   out        bin, count, counted                               strobe
// config   in         cfg_index, cfg_data                               cfg_valid, cfg_ready
//
// A command beat is taken when start is high and busy is low; busy then stays high for one cycle.
// Each command gives one result strobe after its capture, lookup and update steps, and a new
// command is refused only while busy covers the lookup of the bin counter RAM read.
// Reset clears all bin counters through per-bin valid flags, so no clearing pass is needed.
// The result cannot be stalled; the strobe is high for exactly one cycle.
module pulse_interval_amplitude_histogram_core (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	output logic                                       busy,
	input  logic [piah_pkg::OP_W-1:0]                  op,
	input  logic [piah_pkg::PHASE_W-1:0]               phase_pos,
	input  logic signed [piah_pkg::AMP_W-1:0]          amplitude,
	input  logic                                       first_of_list,
	input  logic [piah_pkg::BIN_OUT_W-1:0]             read_bin,
	output logic                                       strobe,
	output logic [piah_pkg::BIN_OUT_W-1:0]             bin,
	output logic [piah_pkg::COUNT_OUT_W-1:0]           count,
	output logic                                       counted,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [piah_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [piah_pkg::CFG_DATA_W-1:0]            cfg_data
);

	piah_pkg::piah_cmd_t cmd;

	assign cfg_ready = 1'b1;

	piah_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd)
	);

	piah_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (op),
		.phase_pos    (phase_pos),
		.amplitude    (amplitude),
		.first_of_list(first_of_list),
		.read_bin     (read_bin),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.strobe       (strobe),
		.bin          (bin),
		.count        (count),
		.counted      (counted)
	);

endmodule
